/* design/assert_macros.svh */
// Assertion helpers shared by the RTL. They compile away when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// When ante holds on a clock edge, cons must hold on the same edge.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// When ante holds on a clock edge, cons must hold on the next edge.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* design/i2cm_pkg.sv */
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
    localparam logic [3:0]  TOP_BIT           = 4'd7;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } i2cm_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_in;
    } i2cm_in_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_received;
        logic       rejected;
    } i2cm_out_t;

    typedef struct packed {
        i2cm_cmd_t   active_command;
        logic [3:0]  phase;
        logic [15:0] delay_count;
        logic [3:0]  bit_index;
        logic [7:0]  shift_reg;
        logic        held_ack_choice;
        logic        last_ack;
        logic        scl_level;
        logic        sda_level;
        logic [7:0]  rx_hold;
    } i2cm_state_t;

    localparam i2cm_state_t STATE_RESET = '{
        active_command:  CMD_IDLE,
        phase:           4'd0,
        delay_count:     16'd0,
        bit_index:       4'd0,
        shift_reg:       8'd0,
        held_ack_choice: 1'b0,
        last_ack:        1'b0,
        scl_level:       1'b1,
        sda_level:       1'b1,
        rx_hold:         8'd0
    };

endpackage

/* design/i2cm_step.sv */
`timescale 1ns / 1ps

module i2cm_step (
    input  i2cm_pkg::i2cm_state_t cur,
    input  i2cm_pkg::i2cm_in_t    item,
    input  logic [15:0]           half_period,
    output i2cm_pkg::i2cm_state_t nxt,
    output i2cm_pkg::i2cm_out_t   res
);
    import i2cm_pkg::*;

    logic [15:0] hold_len;
    logic        do_step;
    logic        done;
    logic        rej;

    // A zero half period behaves like a half period of one tick.
    assign hold_len = (half_period == 16'd0) ? 16'd0 : half_period - 16'd1;

    always_comb
    begin
        nxt     = cur;
        do_step = 1'b0;
        done    = 1'b0;
        rej     = 1'b0;

        if (cur.active_command != CMD_IDLE)
        begin
            rej = (item.func != 3'd0);
            if (cur.delay_count != 16'd0)
            begin
                nxt.delay_count = cur.delay_count - 16'd1;
            end
            else
            begin
                do_step = 1'b1;
            end
        end
        else if (item.func >= 3'(CMD_START) && item.func <= 3'(CMD_READ))
        begin
            nxt.active_command = i2cm_cmd_t'(item.func);
            nxt.phase = 4'd0;
            if (item.func == 3'(CMD_WRITE))
            begin
                nxt.shift_reg = item.tx_byte;
            end
            if (item.func == 3'(CMD_READ))
            begin
                nxt.held_ack_choice = item.ack_to_send;
            end
            do_step = 1'b1;
        end
        else if (item.func != 3'd0)
        begin
            rej = 1'b1;
        end

        if (do_step)
        begin
            // Each step may set line levels and either schedules the next step after
            // a hold or ends the command with no hold.
            case (nxt.active_command)
                CMD_START:
                begin
                    case (nxt.phase)
                        4'd0:
                        begin
                            nxt.phase = 4'd1;
                            nxt.delay_count = hold_len;
                        end
                        4'd1:
                        begin
                            nxt.sda_level = 1'b1;
                            nxt.scl_level = 1'b1;
                            nxt.phase = 4'd2;
                            nxt.delay_count = hold_len;
                        end
                        4'd2:
                        begin
                            nxt.sda_level = 1'b0;
                            nxt.phase = 4'd3;
                            nxt.delay_count = hold_len;
                        end
                        default:
                        begin
                            nxt.scl_level = 1'b0;
                            done = 1'b1;
                        end
                    endcase
                end
                CMD_STOP:
                begin
                    case (nxt.phase)
                        4'd0:
                        begin
                            nxt.phase = 4'd1;
                            nxt.delay_count = hold_len;
                        end
                        4'd1:
                        begin
                            nxt.sda_level = 1'b0;
                            nxt.phase = 4'd2;
                            nxt.delay_count = hold_len;
                        end
                        4'd2:
                        begin
                            nxt.scl_level = 1'b1;
                            nxt.phase = 4'd3;
                            nxt.delay_count = hold_len;
                        end
                        4'd3:
                        begin
                            nxt.sda_level = 1'b1;
                            nxt.phase = 4'd4;
                            nxt.delay_count = hold_len;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
                CMD_WRITE:
                begin
                    case (nxt.phase)
                        4'd0:
                        begin
                            nxt.bit_index = TOP_BIT;
                            nxt.phase = 4'd1;
                            nxt.delay_count = hold_len;
                        end
                        4'd1:
                        begin
                            // The first data bit leaves SCL where the previous command left it.
                            if (nxt.bit_index != TOP_BIT)
                            begin
                                nxt.scl_level = 1'b0;
                            end
                            nxt.sda_level = nxt.shift_reg[nxt.bit_index[2:0]];
                            nxt.phase = 4'd2;
                            nxt.delay_count = hold_len;
                        end
                        4'd2:
                        begin
                            nxt.scl_level = 1'b1;
                            if (nxt.bit_index == 4'd0)
                            begin
                                nxt.phase = 4'd3;
                            end
                            else
                            begin
                                nxt.bit_index = nxt.bit_index - 4'd1;
                                nxt.phase = 4'd1;
                            end
                            nxt.delay_count = hold_len;
                        end
                        4'd3:
                        begin
                            nxt.scl_level = 1'b0;
                            nxt.sda_level = 1'b1;
                            nxt.phase = 4'd4;
                            nxt.delay_count = hold_len;
                        end
                        4'd4:
                        begin
                            nxt.scl_level = 1'b1;
                            nxt.phase = 4'd5;
                            nxt.delay_count = hold_len;
                        end
                        4'd5:
                        begin
                            nxt.phase = 4'd6;
                            nxt.delay_count = hold_len;
                        end
                        4'd6:
                        begin
                            nxt.last_ack = ~item.sda_in;
                            nxt.scl_level = 1'b0;
                            nxt.phase = 4'd7;
                            nxt.delay_count = hold_len;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
                CMD_READ:
                begin
                    case (nxt.phase)
                        4'd0:
                        begin
                            nxt.phase = 4'd1;
                            nxt.delay_count = hold_len;
                        end
                        4'd1:
                        begin
                            nxt.phase = 4'd2;
                            nxt.delay_count = hold_len;
                        end
                        4'd2:
                        begin
                            nxt.sda_level = 1'b1;
                            nxt.bit_index = 4'd0;
                            nxt.shift_reg = 8'd0;
                            nxt.phase = 4'd3;
                            nxt.delay_count = hold_len;
                        end
                        4'd3:
                        begin
                            nxt.scl_level = 1'b1;
                            nxt.phase = 4'd4;
                            nxt.delay_count = hold_len;
                        end
                        4'd4:
                        begin
                            nxt.shift_reg = {nxt.shift_reg[6:0], item.sda_in};
                            nxt.scl_level = 1'b0;
                            nxt.bit_index = nxt.bit_index + 4'd1;
                            nxt.phase = (nxt.bit_index < BITS_PER_BYTE) ? 4'd3 : 4'd5;
                            nxt.delay_count = hold_len;
                        end
                        4'd5:
                        begin
                            nxt.phase = 4'd6;
                            nxt.delay_count = hold_len;
                        end
                        4'd6:
                        begin
                            nxt.sda_level = ~nxt.held_ack_choice;
                            nxt.phase = 4'd7;
                            nxt.delay_count = hold_len;
                        end
                        4'd7:
                        begin
                            nxt.scl_level = 1'b1;
                            nxt.phase = 4'd8;
                            nxt.delay_count = hold_len;
                        end
                        default:
                        begin
                            nxt.scl_level = 1'b0;
                            nxt.sda_level = 1'b1;
                            nxt.rx_hold = nxt.shift_reg;
                            done = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase

            if (done)
            begin
                nxt.active_command = CMD_IDLE;
                nxt.phase = 4'd0;
                nxt.delay_count = 16'd0;
            end
        end
    end

    assign res.scl          = nxt.scl_level;
    assign res.sda_out      = nxt.sda_level;
    assign res.busy_res     = (nxt.active_command != CMD_IDLE);
    assign res.done_res     = done;
    assign res.rx_byte      = nxt.rx_hold;
    assign res.ack_received = nxt.last_ack;
    assign res.rejected     = rej;

endmodule

/* design/i2c_master_byte_engine.sv */
`timescale 1ns / 1ps
// Bit-banged I2C master byte engine. Each request on the input channel is one
// tick of bus time and may carry a command: start, stop, write byte or read byte.
// For every request the block returns exactly one result on the output channel:
// the SCL and SDA levels after that tick, busy and done flags, the last read
// byte, the last write's ACK and a flag for a command that was ignored.
// The user must see that half_period is written through cfg_we/cfg_wdata only
// while the engine is idle; the block itself does not enforce this. An accepted
// request waits in the input register and is processed into the result register
// once that one is free. Throughput: one request per cycle while the receiver
// takes results; the bus sequencer state updates once per request in a single
// pass of combinational logic between the input register and the result register.
// When the receiver stalls, the result register and the input register hold,
// in_ready drops once both are full, and the sequencer state does not advance.
// Reset: half_period returns to 100, the sequencer's SCL and SDA levels are set
// high, the engine is idle and both pipeline registers are empty.
module i2c_master_byte_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cm_pkg::i2cm_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cm_pkg::i2cm_out_t out_data
);
    import i2cm_pkg::*;

`include "assert_macros.svh"

    logic [15:0] half_period_reg;
    logic        in_valid_reg;
    i2cm_in_t    in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    i2cm_out_t   out_data_reg;
    i2cm_state_t state_reg;
    i2cm_state_t state_next;
    i2cm_out_t   step_res;
    logic        advance;

    // The input register moves into the result register when that one is free.
    assign advance        = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !in_valid_reg || advance;
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    i2cm_step u_step (
        .cur         (state_reg),
        .item        (in_data_reg),
        .half_period (half_period_reg),
        .nxt         (state_next),
        .res         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= STATE_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                half_period_reg <= cfg_wdata;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= step_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_IMPL(a_done_not_busy, clk, rst_n, out_valid_reg && out_data_reg.done_res,
        !out_data_reg.busy_res)
    `ASSERT_IMPL(a_idle_clean, clk, rst_n, state_reg.active_command == CMD_IDLE,
        state_reg.delay_count == 16'd0 && state_reg.phase == 4'd0)
    `ASSERT_IMPL(a_bit_index_range, clk, rst_n, 1'b1, state_reg.bit_index <= BITS_PER_BYTE)
    `ASSERT_NEXT(a_result_lands, clk, rst_n, advance, out_valid_reg)

endmodule

/* verif/i2c_master_byte_engine_test.sv */
`timescale 1ns / 1ps

module i2c_master_byte_engine_test;
    import i2cm_pkg::*;

    localparam logic [2:0] FUNC_BAD_LO = 3'd5;
    localparam logic [2:0] FUNC_BAD_HI = 3'd7;
    localparam int SDA_LOW = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;
    localparam int QUIET_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 30;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic in_valid = 1'b0;
    logic in_ready;
    i2cm_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    i2cm_out_t out_data;

    i2c_master_byte_engine dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Bus engine predictor state.
    i2cm_cmd_t eng_cmd = CMD_IDLE;
    logic [3:0] eng_phase = 4'd0;
    logic [15:0] hold_left = 16'd0;
    logic [3:0] bit_pos = 4'd0;
    logic [7:0] shifter = 8'd0;
    logic ack_plan = 1'b0;
    logic slave_ack = 1'b0;
    logic scl_lvl = 1'b1;
    logic sda_lvl = 1'b1;
    logic [7:0] rx_last = 8'd0;
    logic [15:0] half_per = HALF_PERIOD_RESET;

    i2cm_in_t ticks_to_send[$];
    i2cm_out_t bus_levels_due[$];
    int n_queued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int mismatches = 0;
    logic in_taken = 1'b0;
    bit calm = 1'b0;
    int send_gap = 0;
    int sink_stall = 0;

    function automatic void arm_hold(input logic [3:0] nxt);
        eng_phase = nxt;
        hold_left = (half_per == 16'd0) ? 16'd0 : half_per - 16'd1;
    endfunction

    function automatic logic end_command();
        eng_cmd = CMD_IDLE;
        eng_phase = 4'd0;
        hold_left = 16'd0;
        return 1'b1;
    endfunction

    // Performs the step named by eng_phase; returns 1 when the command ends.
    function automatic logic bus_step(input logic sda_now);
        logic fin;
        fin = 1'b0;
        case (eng_cmd)
            CMD_START:
                case (eng_phase)
                    4'd0: arm_hold(4'd1);
                    4'd1:
                    begin
                        sda_lvl = 1'b1;
                        scl_lvl = 1'b1;
                        arm_hold(4'd2);
                    end
                    4'd2:
                    begin
                        sda_lvl = 1'b0;
                        arm_hold(4'd3);
                    end
                    default:
                    begin
                        scl_lvl = 1'b0;
                        fin = end_command();
                    end
                endcase
            CMD_STOP:
                case (eng_phase)
                    4'd0: arm_hold(4'd1);
                    4'd1:
                    begin
                        sda_lvl = 1'b0;
                        arm_hold(4'd2);
                    end
                    4'd2:
                    begin
                        scl_lvl = 1'b1;
                        arm_hold(4'd3);
                    end
                    4'd3:
                    begin
                        sda_lvl = 1'b1;
                        arm_hold(4'd4);
                    end
                    default: fin = end_command();
                endcase
            CMD_WRITE:
                case (eng_phase)
                    4'd0:
                    begin
                        bit_pos = TOP_BIT;
                        arm_hold(4'd1);
                    end
                    4'd1:
                    begin
                        // The first bit keeps SCL where the previous command left it.
                        if (bit_pos != TOP_BIT)
                            scl_lvl = 1'b0;
                        sda_lvl = shifter[bit_pos[2:0]];
                        arm_hold(4'd2);
                    end
                    4'd2:
                    begin
                        scl_lvl = 1'b1;
                        if (bit_pos == 4'd0)
                            arm_hold(4'd3);
                        else
                        begin
                            bit_pos = bit_pos - 4'd1;
                            arm_hold(4'd1);
                        end
                    end
                    4'd3:
                    begin
                        scl_lvl = 1'b0;
                        sda_lvl = 1'b1;
                        arm_hold(4'd4);
                    end
                    4'd4:
                    begin
                        scl_lvl = 1'b1;
                        arm_hold(4'd5);
                    end
                    4'd5: arm_hold(4'd6);
                    4'd6:
                    begin
                        slave_ack = (sda_now == 1'b0);
                        scl_lvl = 1'b0;
                        arm_hold(4'd7);
                    end
                    default: fin = end_command();
                endcase
            CMD_READ:
                case (eng_phase)
                    4'd0: arm_hold(4'd1);
                    4'd1: arm_hold(4'd2);
                    4'd2:
                    begin
                        sda_lvl = 1'b1;
                        bit_pos = 4'd0;
                        shifter = 8'd0;
                        arm_hold(4'd3);
                    end
                    4'd3:
                    begin
                        scl_lvl = 1'b1;
                        arm_hold(4'd4);
                    end
                    4'd4:
                    begin
                        shifter = {shifter[6:0], sda_now};
                        scl_lvl = 1'b0;
                        bit_pos = bit_pos + 4'd1;
                        arm_hold((bit_pos < BITS_PER_BYTE) ? 4'd3 : 4'd5);
                    end
                    4'd5: arm_hold(4'd6);
                    4'd6:
                    begin
                        sda_lvl = ack_plan ? 1'b0 : 1'b1;
                        arm_hold(4'd7);
                    end
                    4'd7:
                    begin
                        scl_lvl = 1'b1;
                        arm_hold(4'd8);
                    end
                    default:
                    begin
                        scl_lvl = 1'b0;
                        sda_lvl = 1'b1;
                        rx_last = shifter;
                        fin = end_command();
                    end
                endcase
            default: fin = end_command();
        endcase
        return fin;
    endfunction

    function automatic i2cm_out_t advance_bus(input i2cm_in_t req);
        i2cm_out_t res;
        logic fin;
        logic rej;
        fin = 1'b0;
        rej = 1'b0;
        if (eng_cmd != CMD_IDLE)
        begin
            if (req.func != CMD_IDLE)
                rej = 1'b1;
            if (hold_left != 16'd0)
                hold_left = hold_left - 16'd1;
            else
                fin = bus_step(req.sda_in);
        end
        else if (req.func >= CMD_START && req.func <= CMD_READ)
        begin
            eng_cmd = i2cm_cmd_t'(req.func);
            eng_phase = 4'd0;
            if (req.func == CMD_WRITE)
                shifter = req.tx_byte;
            if (req.func == CMD_READ)
                ack_plan = req.ack_to_send;
            fin = bus_step(req.sda_in);
        end
        else if (req.func != CMD_IDLE)
            rej = 1'b1;
        res.scl = scl_lvl;
        res.sda_out = sda_lvl;
        res.busy_res = (eng_cmd != CMD_IDLE);
        res.done_res = fin;
        res.rx_byte = rx_last;
        res.ack_received = slave_ack;
        res.rejected = rej;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Request driver and result sink, both moving on the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_taken)
            begin
                if (send_gap > 0 || ticks_to_send.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
                else
                begin
                    in_data <= ticks_to_send.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end
            end
            if (sink_stall > 0)
            begin
                out_ready <= 1'b0;
                sink_stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                sink_stall = pick_gap();
            end
        end
    end

    // Accepted requests feed the predictor; accepted results are checked.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                bus_levels_due.push_back(advance_bus(in_data));
                n_accepted++;
            end
            if (out_valid && out_ready)
            begin
                n_results++;
                if (bus_levels_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("result %0d arrived with nothing expected", n_results);
                    mismatches++;
                end
                else if (out_data !== bus_levels_due[0])
                begin
                    if (mismatches < 10)
                        $display({"result %0d: scl %b/%b sda %b/%b busy %b/%b done %b/%b",
                                  " rx %h/%h ack %b/%b rej %b/%b (expected/actual)"},
                                 n_results,
                                 bus_levels_due[0].scl, out_data.scl,
                                 bus_levels_due[0].sda_out, out_data.sda_out,
                                 bus_levels_due[0].busy_res, out_data.busy_res,
                                 bus_levels_due[0].done_res, out_data.done_res,
                                 bus_levels_due[0].rx_byte, out_data.rx_byte,
                                 bus_levels_due[0].ack_received, out_data.ack_received,
                                 bus_levels_due[0].rejected, out_data.rejected);
                    mismatches++;
                    void'(bus_levels_due.pop_front());
                end
                else
                    void'(bus_levels_due.pop_front());
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("i2c_master_byte_engine_test: done, errors");
        $finish;
    end

    function automatic logic pick_sda(input int sel);
        if (sel == SDA_LOW)
            return 1'b0;
        if (sel == SDA_HIGH)
            return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic int hold_steps(input logic [2:0] f);
        case (f)
            CMD_START: return 3;
            CMD_STOP:  return 4;
            CMD_WRITE: return 21;
            CMD_READ:  return 22;
            default:   return 0;
        endcase
    endfunction

    task automatic queue_req(input logic [2:0] f, input logic [7:0] tx, input logic ack,
                             input logic sda);
        i2cm_in_t req;
        req.func = f;
        req.tx_byte = tx;
        req.ack_to_send = ack;
        req.sda_in = sda;
        ticks_to_send.push_back(req);
        n_queued++;
    endtask

    task automatic queue_ticks(input int n, input int sda_sel);
        for (int i = 0; i < n; i++)
            queue_req(CMD_IDLE, 8'($urandom), 1'($urandom), pick_sda(sda_sel));
    endtask

    // A command followed by exactly enough ticks for it to finish. Each tick
    // that follows carries a stray command with probability noise_pct.
    task automatic queue_command(input logic [2:0] f, input logic [7:0] tx, input logic ack,
                                 input int sda_sel, input int noise_pct);
        int ticks;
        logic [2:0] f_tick;
        ticks = hold_steps(f) * ((half_per == 16'd0) ? 1 : int'(half_per));
        queue_req(f, tx, ack, pick_sda(sda_sel));
        for (int i = 0; i < ticks; i++)
        begin
            f_tick = ($urandom_range(1, 100) <= noise_pct) ? 3'($urandom_range(1, 7)) : CMD_IDLE;
            queue_req(f_tick, 8'($urandom), 1'($urandom), pick_sda(sda_sel));
        end
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || n_results != n_accepted)
            @(negedge clk);
    endtask

    // Brings the engine to idle with nothing in flight.
    task automatic settle();
        wait_drained();
        while (eng_cmd != CMD_IDLE)
        begin
            queue_ticks(int'(hold_left) + 1, SDA_RAND);
            wait_drained();
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_half_period(input logic [15:0] v);
        @(negedge clk);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        half_per = v;
    endtask

    // Random commands until about target requests have been queued.
    task automatic random_traffic(input int target);
        int base;
        int r;
        int nbytes;
        int sel;
        int noise;
        base = n_queued;
        while (n_queued - base < target)
        begin
            r = $urandom_range(0, 99);
            noise = ($urandom_range(0, 99) < 5) ? 10 : 0;
            if (r < 75)
            begin
                nbytes = $urandom_range(1, 2);
                queue_command(CMD_START, 8'($urandom), 1'($urandom), SDA_RAND, noise);
                for (int i = 0; i < nbytes; i++)
                begin
                    sel = $urandom_range(0, 9);
                    sel = (sel == 0) ? SDA_LOW : (sel == 1) ? SDA_HIGH : SDA_RAND;
                    queue_command($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                                  8'($urandom), 1'($urandom), sel, noise);
                end
                queue_command(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RAND, noise);
            end
            else if (r < 85)
            begin
                queue_command(3'($urandom_range(CMD_START, CMD_READ)), 8'($urandom),
                              1'($urandom), SDA_RAND, noise);
            end
            else if (r < 93)
            begin
                queue_req(3'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI)), 8'($urandom),
                          1'($urandom), 1'($urandom));
            end
            else
                queue_ticks($urandom_range(1, 5), SDA_RAND);
            if ($urandom_range(0, 9) < 3)
                queue_ticks($urandom_range(1, 3), SDA_RAND);
        end
    endtask

    initial
    begin : stimulus
        int hp_plan[2];
        hp_plan = '{0, 2};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset half period: one start.
        queue_command(CMD_START, 8'h00, 1'b0, SDA_RAND, 0);
        settle();

        write_half_period(16'd1);
        for (logic [2:0] f = FUNC_BAD_LO; f <= FUNC_BAD_HI && f != 3'd0; f++)
            queue_req(f, 8'($urandom), 1'($urandom), 1'($urandom));
        queue_ticks(1, SDA_RAND);
        queue_command(CMD_START, 8'h00, 1'b0, SDA_RAND, 0);
        queue_command(CMD_WRITE, 8'h00, 1'b0, SDA_LOW, 0);
        queue_command(CMD_WRITE, 8'hFF, 1'b1, SDA_HIGH, 0);
        queue_command(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 0);
        queue_command(CMD_READ, 8'hFF, 1'b0, SDA_LOW, 0);
        // Every tick of these two carries a stray command, the finishing tick too.
        queue_command(CMD_WRITE, 8'hA5, 1'b0, SDA_RAND, 100);
        queue_command(CMD_READ, 8'h3C, 1'b1, SDA_RAND, 100);
        queue_command(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 0);
        queue_command(CMD_START, 8'h00, 1'b0, SDA_RAND, 0);
        queue_command(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 0);
        // A write with SCL still high from the stop leaves it high for the first bit.
        queue_command(CMD_WRITE, 8'h5A, 1'b0, SDA_LOW, 0);
        settle();

        for (int p = 0; p < 2; p++)
        begin
            // The second phase runs without idling on either side.
            calm = (p == 1);
            write_half_period(16'(hp_plan[p]));
            random_traffic(ITEMS_PER_PHASE);
            settle();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (bus_levels_due.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("i2c_master_byte_engine_test: done, clean");
        else
            $display("i2c_master_byte_engine_test: done, errors");
        $finish;
    end

endmodule
